### hdl/csac_pkg.sv
// ----------------------------------------------------------------------------
// csac_pkg: shared types and constants of the cache set cost model
// Widths, operation codes, register indexes, controller states and the
// command group from controller to datapath.
// ----------------------------------------------------------------------------
package csac_pkg;

	// set geometry
	localparam int MAX_WAYS = 8;
	localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int CNT_W    = $clog2(MAX_WAYS + 1);

	// field widths
	localparam int TAG_W   = 32;
	localparam int FUNC_W  = 2;
	localparam int CYC_W   = 22;
	localparam int WAYS_W  = 4;
	localparam int WORDS_W = 9;
	localparam int MEM_W   = 10;
	localparam int CACHE_W = 4;
	localparam int BLK_W   = MEM_W + WORDS_W;
	localparam int SUM_W   = CYC_W + 2;
	localparam int PROD_W  = CNT_W + BLK_W;

	localparam logic [CYC_W-1:0] CYCLES_MAX = {CYC_W{1'b1}};

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_STORE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_ALLOC = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WB    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LRU   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WORDS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MEM   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CACHE = 3'd6;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_UPD
	} csac_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic cap_in;   // capture the accepted word
		logic look;     // register compare, dirty count and block cost
		logic commit;   // update the set and load the result register
	} csac_cmd_t;

endpackage

### hdl/csac_ctrl.sv
// ----------------------------------------------------------------------------
// csac_ctrl: sequencing of one access
// Steps each word through a lookup cycle and an update cycle, and owns the
// handshake on both streams.
// ----------------------------------------------------------------------------
module csac_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output csac_pkg::csac_cmd_t cmd
);

	csac_pkg::csac_state_t state_q, state_nxt;
	logic                  out_valid_q;
	logic                  out_free;
	logic                  accept;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			csac_pkg::ST_IDLE: begin
				if (s_tvalid) state_nxt = csac_pkg::ST_LOOK;
			end
			csac_pkg::ST_LOOK: begin
				state_nxt = csac_pkg::ST_UPD;
			end
			csac_pkg::ST_UPD: begin
				if (out_free) state_nxt = s_tvalid ? csac_pkg::ST_LOOK : csac_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = csac_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		s_tready   = 1'b0;
		cmd.look   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			csac_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			csac_pkg::ST_LOOK: begin
				cmd.look = 1'b1;
			end
			csac_pkg::ST_UPD: begin
				// take the next word in the same cycle the result leaves
				s_tready   = out_free;
				cmd.commit = out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
		accept     = s_tvalid && s_tready;
		cmd.cap_in = accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= csac_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

endmodule

### hdl/csac_dp.sv
// ----------------------------------------------------------------------------
// csac_dp: set storage, configuration and cost datapath
// Holds the ordered entry list, compares tags, computes the access cost and
// shifts the list on reorder or eviction.
// ----------------------------------------------------------------------------
module csac_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  csac_pkg::csac_cmd_t                 cmd,
	input  logic [csac_pkg::FUNC_W-1:0]         in_func,
	input  logic [csac_pkg::TAG_W-1:0]          in_tag,
	input  logic                                cfg_we,
	input  logic [csac_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [csac_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                out_hit,
	output logic [csac_pkg::CYC_W-1:0]          out_cycles,
	output logic                                out_bad
);

	localparam int MW = csac_pkg::MAX_WAYS;

	// configuration
	logic                               alloc_q, wb_q, lru_q;
	logic [csac_pkg::WAYS_W-1:0]        ways_q;
	logic [csac_pkg::WORDS_W-1:0]       words_q;
	logic [csac_pkg::MEM_W-1:0]         mem_q;
	logic [csac_pkg::CACHE_W-1:0]       cache_q;

	// accepted word
	logic [csac_pkg::FUNC_W-1:0]        func_q;
	logic [csac_pkg::TAG_W-1:0]         tag_in_q;

	// set contents
	logic [csac_pkg::TAG_W-1:0]         ent_tag_q   [MW];
	logic [MW-1:0]                      ent_dirty_q;
	logic [csac_pkg::CNT_W-1:0]         fill_q;

	// lookup stage
	logic                               hit_s1, hit_dirty_s1;
	logic [csac_pkg::WAY_W-1:0]         idx_s1;
	logic [csac_pkg::CNT_W-1:0]         ndirty_s1;
	logic [csac_pkg::BLK_W-1:0]         blk_s1;

	logic [MW-1:0]                      valid_mask, match;
	logic                               hit_c;
	logic [csac_pkg::WAY_W-1:0]         idx_c;
	logic [csac_pkg::CNT_W-1:0]         ndirty_c;

	always_comb begin
		hit_c    = 1'b0;
		idx_c    = '0;
		ndirty_c = '0;
		for (int i = 0; i < MW; i++) begin
			valid_mask[i] = csac_pkg::CNT_W'(i) < fill_q;
			match[i]      = valid_mask[i] && (ent_tag_q[i] == tag_in_q);
		end
		// lowest matching way wins
		for (int i = MW - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_c = 1'b1;
				idx_c = csac_pkg::WAY_W'(i);
			end
		end
		for (int i = 0; i < MW; i++) begin
			ndirty_c = ndirty_c + csac_pkg::CNT_W'(valid_mask[i] && ent_dirty_q[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			func_q   <= in_func;
			tag_in_q <= in_tag;
		end
		if (cmd.look) begin
			hit_s1       <= hit_c;
			idx_s1       <= idx_c;
			hit_dirty_s1 <= |(match & ent_dirty_q);
			ndirty_s1    <= ndirty_c;
			blk_s1       <= csac_pkg::BLK_W'(mem_q) * csac_pkg::BLK_W'(words_q);
		end
	end

	// update stage
	logic                               is_load, is_store, is_flush, alloc;
	logic [csac_pkg::CNT_W-1:0]         eff_ways, fill_m1, fill_nxt;
	logic                               full;
	logic [csac_pkg::WAY_W-1:0]         rm_idx, end_idx;
	logic                               wr_en, new_dirty;
	logic [csac_pkg::SUM_W-1:0]         st_cost, blk_ext, sum;
	logic [csac_pkg::PROD_W-1:0]        flush_prod;
	logic                               res_hit, res_bad;
	logic [csac_pkg::CYC_W-1:0]         res_cyc;
	logic [MW-1:0]                      dirty_nxt;

	always_comb begin
		is_load  = func_q == csac_pkg::FUNC_LOAD;
		is_store = func_q == csac_pkg::FUNC_STORE;
		is_flush = func_q == csac_pkg::FUNC_FLUSH;
		alloc    = (is_load || is_store) && !hit_s1 && (is_load || alloc_q);

		if (ways_q == '0) eff_ways = csac_pkg::CNT_W'(1);
		else if (32'(ways_q) > MW) eff_ways = csac_pkg::CNT_W'(MW);
		else eff_ways = csac_pkg::CNT_W'(ways_q);

		full     = fill_q >= eff_ways;
		fill_m1  = fill_q - csac_pkg::CNT_W'(1);
		fill_nxt = fill_q;

		st_cost = wb_q ? csac_pkg::SUM_W'(cache_q)
		               : csac_pkg::SUM_W'(mem_q) + csac_pkg::SUM_W'(cache_q);
		blk_ext = csac_pkg::SUM_W'(blk_s1);
		flush_prod = csac_pkg::PROD_W'(ndirty_s1) * csac_pkg::PROD_W'(blk_s1);

		wr_en     = 1'b0;
		rm_idx    = '0;
		end_idx   = '0;
		new_dirty = 1'b0;
		sum       = '0;
		res_hit   = 1'b0;
		res_bad   = 1'b0;

		if ((is_load || is_store) && hit_s1) begin
			res_hit   = 1'b1;
			wr_en     = 1'b1;
			rm_idx    = idx_s1;
			end_idx   = lru_q ? fill_m1[csac_pkg::WAY_W-1:0] : idx_s1;
			new_dirty = hit_dirty_s1 || (is_store && wb_q);
			sum       = is_load ? csac_pkg::SUM_W'(cache_q) : st_cost;
		end else if (alloc) begin
			wr_en     = 1'b1;
			new_dirty = is_store && wb_q;
			sum       = blk_ext + (is_store ? st_cost : '0);
			if (full) begin
				// evict the oldest way, shift the rest down
				rm_idx  = '0;
				end_idx = fill_m1[csac_pkg::WAY_W-1:0];
				if (ent_dirty_q[0]) sum = sum + blk_ext;
			end else begin
				rm_idx   = fill_q[csac_pkg::WAY_W-1:0];
				end_idx  = fill_q[csac_pkg::WAY_W-1:0];
				fill_nxt = fill_q + csac_pkg::CNT_W'(1);
			end
		end else if (is_store) begin
			// store miss without allocation
			if (wb_q) res_bad = 1'b1;
			else sum = csac_pkg::SUM_W'(mem_q);
		end else if (is_flush) begin
			if (flush_prod > csac_pkg::PROD_W'(csac_pkg::CYCLES_MAX))
				sum = csac_pkg::SUM_W'(csac_pkg::CYCLES_MAX);
			else
				sum = csac_pkg::SUM_W'(flush_prod);
		end

		if (sum > csac_pkg::SUM_W'(csac_pkg::CYCLES_MAX)) res_cyc = csac_pkg::CYCLES_MAX;
		else res_cyc = sum[csac_pkg::CYC_W-1:0];
	end

	// entry list: shift ways in [rm_idx, end_idx) down, write end_idx
	for (genvar i = 0; i < MW; i++) begin : g_way
		logic sel_end, sel_shift;
		assign sel_end   = csac_pkg::WAY_W'(i) == end_idx;
		assign sel_shift = (csac_pkg::WAY_W'(i) >= rm_idx) && (csac_pkg::WAY_W'(i) < end_idx);
		assign dirty_nxt[i] = sel_end ? new_dirty
		                    : sel_shift ? ent_dirty_q[(i + 1) % MW] : ent_dirty_q[i];

		always_ff @(posedge clk) begin
			if (cmd.commit && wr_en) begin
				if (sel_end) ent_tag_q[i] <= tag_in_q;
				else if (sel_shift) ent_tag_q[i] <= ent_tag_q[(i + 1) % MW];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_dirty_q <= '0;
		end else if (cmd.commit && wr_en) begin
			ent_dirty_q <= dirty_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			alloc_q <= 1'b1;
			wb_q    <= 1'b1;
			lru_q   <= 1'b1;
			ways_q  <= csac_pkg::WAYS_W'(8);
			words_q <= csac_pkg::WORDS_W'(4);
			mem_q   <= csac_pkg::MEM_W'(100);
			cache_q <= csac_pkg::CACHE_W'(1);
		end else begin
			if (cmd.commit) fill_q <= fill_nxt;
			if (cfg_we) begin
				case (cfg_index)
					csac_pkg::CFG_ALLOC: alloc_q <= cfg_data[0];
					csac_pkg::CFG_WB:    wb_q    <= cfg_data[0];
					csac_pkg::CFG_LRU:   lru_q   <= cfg_data[0];
					csac_pkg::CFG_WAYS:  ways_q  <= cfg_data[csac_pkg::WAYS_W-1:0];
					csac_pkg::CFG_WORDS: words_q <= cfg_data[csac_pkg::WORDS_W-1:0];
					csac_pkg::CFG_MEM:   mem_q   <= cfg_data[csac_pkg::MEM_W-1:0];
					csac_pkg::CFG_CACHE: cache_q <= cfg_data[csac_pkg::CACHE_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_hit    <= res_hit;
			out_cycles <= res_cyc;
			out_bad    <= res_bad;
		end
	end

endmodule

### hdl/cache_set_access_cost_model.sv
// ----------------------------------------------------------------------------
// cache_set_access_cost_model: one cache set as an access cost model
// Keeps the ordered way list of one set and reports hit and cost per access.
// ----------------------------------------------------------------------------
// Each input word is a load, a store or a flush query on one set of up to
// eight ways. A lookup cycle compares the tag against every filled way at
// once, counts the dirty ways and forms the block cost (memory cycles times
// words per block) in one multiplier; an update cycle computes the cost,
// shifts the way list for an LRU reorder or an eviction and loads the
// result register. The next word is taken in that update cycle as long as
// the result register is empty or being drained; the input is closed in
// the lookup cycle, so a new word is taken only once the last one reaches
// its update cycle. A full result register with m_tready low holds the
// update cycle and stalls the input. The dirty marks and the fill count
// clear at reset; tags are not cleared and there is no clearing pass.
// Write the configuration only while no word is in flight; writes are taken
// in every cycle and an index past the last register is ignored.
// ----------------------------------------------------------------------------
module cache_set_access_cost_model (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [31:0]                       s_tdata,   // [31:0] tag
	input  logic [1:0]                        s_tuser,   // [1:0] func
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [23:0]                       m_tdata,   // [0] hit, [22:1] cycles,
	                                                     // [23] bad_combination
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [csac_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [csac_pkg::CFG_DATA_W-1:0]   cfg_data
);

	csac_pkg::csac_cmd_t          cmd;
	logic                         out_hit, out_bad;
	logic [csac_pkg::CYC_W-1:0]   out_cycles;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	csac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	csac_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_func    (s_tuser),
		.in_tag     (s_tdata),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_hit    (out_hit),
		.out_cycles (out_cycles),
		.out_bad    (out_bad)
	);

	// pack the result word, hit in the lowest bit
	assign m_tdata = {out_bad, out_cycles, out_hit};

	// a word just taken spends its lookup cycle with the input closed
	a_look_closed: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted during lookup cycle");

	// the bad combination reports no hit and no cost
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[23] |-> !m_tdata[0] && m_tdata[22:1] == '0)
		else $error("bad combination result carries hit or cost");

	// a result is only produced by a commit, which opens the input again
	// after the lookup cycle with the input closed
	a_result_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tready, 1) && $past(!s_tready, 2))
		else $error("result appeared without a preceding update cycle");

endmodule

### tb/sv/cache_set_access_cost_model_checker.sv
// ----------------------------------------------------------------------------
// cache_set_access_cost_model_checker: cost predictor and result checker
// Watches the input, result and configuration channels of the cache set
// cost model. It keeps its own copy of the way list and the registers,
// predicts hit, cost and rejection for every accepted word, and compares
// each result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module cache_set_access_cost_model_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [csac_pkg::TAG_W-1:0]      s_tdata,   // [31:0] tag
	input  logic [csac_pkg::FUNC_W-1:0]     s_tuser,   // [1:0] func
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [csac_pkg::CYC_W+1:0]      m_tdata,   // [0] hit, [22:1] cycles,
	                                                   // [23] bad_combination
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [csac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [csac_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              pending,
	output int                              errors,
	output int                              n_checked,
	output int                              n_hits,
	output int                              n_bad
);
	timeunit 1ns;
	timeprecision 1ps;

	// same layout as m_tdata
	typedef struct packed {
		logic                       bad;
		logic [csac_pkg::CYC_W-1:0] cycles;
		logic                       hit;
	} cost_rec_t;

	cost_rec_t costs_due [$];

	// way list, oldest first
	logic [csac_pkg::TAG_W-1:0] way_tag   [csac_pkg::MAX_WAYS];
	logic                       way_dirty [csac_pkg::MAX_WAYS];
	int                         n_filled;

	logic                         alloc_cfg, wb_cfg, lru_cfg;
	logic [csac_pkg::WAYS_W-1:0]  ways_cfg;
	logic [csac_pkg::WORDS_W-1:0] words_cfg;
	logic [csac_pkg::MEM_W-1:0]   mem_cfg;
	logic [csac_pkg::CACHE_W-1:0] cache_cfg;

	function automatic int unsigned sat_add(int unsigned a, int unsigned b);
		longint unsigned s;
		s = longint'(a) + longint'(b);
		return (s > csac_pkg::CYCLES_MAX) ? int'(csac_pkg::CYCLES_MAX) : int'(s);
	endfunction

	function automatic int eff_ways();
		if (ways_cfg == 0)
			return 1;
		if (ways_cfg > csac_pkg::MAX_WAYS)
			return csac_pkg::MAX_WAYS;
		return int'(ways_cfg);
	endfunction

	function automatic void to_young(int idx);
		logic [csac_pkg::TAG_W-1:0] t;
		logic                       d;
		t = way_tag[idx];
		d = way_dirty[idx];
		for (int i = idx; i + 1 < n_filled; i++) begin
			way_tag[i]   = way_tag[i + 1];
			way_dirty[i] = way_dirty[i + 1];
		end
		way_tag[n_filled - 1]   = t;
		way_dirty[n_filled - 1] = d;
	endfunction

	// append a block at the young end, evicting the oldest when full
	function automatic int unsigned bring_in(logic [csac_pkg::TAG_W-1:0] t, int unsigned blk);
		int unsigned c;
		c = 0;
		if (n_filled < eff_ways()) begin
			n_filled++;
		end else begin
			if (way_dirty[0])
				c = blk;
			for (int i = 0; i + 1 < n_filled; i++) begin
				way_tag[i]   = way_tag[i + 1];
				way_dirty[i] = way_dirty[i + 1];
			end
		end
		way_tag[n_filled - 1]   = t;
		way_dirty[n_filled - 1] = 1'b0;
		return sat_add(c, blk);
	endfunction

	function automatic int unsigned store_cost(int idx);
		if (wb_cfg) begin
			way_dirty[idx] = 1'b1;
			return int'(cache_cfg);
		end
		return int'(mem_cfg) + int'(cache_cfg);
	endfunction

	function automatic cost_rec_t access_cost(logic [csac_pkg::FUNC_W-1:0] f,
		logic [csac_pkg::TAG_W-1:0] t);
		cost_rec_t   r;
		int unsigned c, blk;
		int          hit_at;
		r   = '0;
		c   = 0;
		blk = int'(mem_cfg) * int'(words_cfg);
		if (f == csac_pkg::FUNC_LOAD || f == csac_pkg::FUNC_STORE) begin
			hit_at = -1;
			for (int i = n_filled - 1; i >= 0; i--)
				if (way_tag[i] == t)
					hit_at = i;
			if (hit_at >= 0) begin
				r.hit = 1'b1;
				c = (f == csac_pkg::FUNC_LOAD) ? int'(cache_cfg) : store_cost(hit_at);
				if (lru_cfg)
					to_young(hit_at);
			end else if (f == csac_pkg::FUNC_LOAD) begin
				c = bring_in(t, blk);
			end else if (alloc_cfg) begin
				c = bring_in(t, blk);
				c = sat_add(c, store_cost(n_filled - 1));
			end else if (wb_cfg) begin
				r.bad = 1'b1;
			end else begin
				c = int'(mem_cfg);
			end
		end else if (f == csac_pkg::FUNC_FLUSH) begin
			for (int i = 0; i < n_filled; i++)
				if (way_dirty[i])
					c = sat_add(c, blk);
		end
		r.cycles = (c > csac_pkg::CYCLES_MAX) ? csac_pkg::CYCLES_MAX
		                                      : c[csac_pkg::CYC_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cost_rec_t want, got;
		if (!arst_n) begin
			costs_due.delete();
			for (int i = 0; i < csac_pkg::MAX_WAYS; i++) begin
				way_tag[i]   = '0;
				way_dirty[i] = 1'b0;
			end
			n_filled  = 0;
			alloc_cfg = 1'b1;
			wb_cfg    = 1'b1;
			lru_cfg   = 1'b1;
			ways_cfg  = 4'd8;
			words_cfg = 9'd4;
			mem_cfg   = 10'd100;
			cache_cfg = 4'd1;
			pending   = 0;
			errors    = 0;
			n_checked = 0;
			n_hits    = 0;
			n_bad     = 0;
		end else begin
			// retire a result word against the oldest prediction
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				n_checked++;
				if (costs_due.size() == 0) begin
					if (errors < 10)
						$display("%0t: result word with none due: hit %0b cycles %0d bad %0b",
							$time, got.hit, got.cycles, got.bad);
					errors++;
				end else begin
					want = costs_due.pop_front();
					if (got.hit !== want.hit || got.cycles !== want.cycles ||
						got.bad !== want.bad) begin
						if (errors < 10)
							$display("%0t: mismatch hit %0b/%0b cycles %0d/%0d bad %0b/%0b (exp/act)",
								$time, want.hit, got.hit, want.cycles, got.cycles,
								want.bad, got.bad);
						errors++;
					end
					if (want.hit)
						n_hits++;
					if (want.bad)
						n_bad++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					csac_pkg::CFG_ALLOC: alloc_cfg = cfg_data[0];
					csac_pkg::CFG_WB:    wb_cfg    = cfg_data[0];
					csac_pkg::CFG_LRU:   lru_cfg   = cfg_data[0];
					csac_pkg::CFG_WAYS:  ways_cfg  = cfg_data[csac_pkg::WAYS_W-1:0];
					csac_pkg::CFG_WORDS: words_cfg = cfg_data[csac_pkg::WORDS_W-1:0];
					csac_pkg::CFG_MEM:   mem_cfg   = cfg_data[csac_pkg::MEM_W-1:0];
					csac_pkg::CFG_CACHE: cache_cfg = cfg_data[csac_pkg::CACHE_W-1:0];
					default: ;
				endcase
			end
			// queue the prediction behind the older ones
			if (s_tvalid && s_tready)
				costs_due.insert(costs_due.size(), access_cost(s_tuser, s_tdata));
			pending = costs_due.size();
		end
	end

endmodule

### tb/sv/cache_set_access_cost_model_tb.sv
// ----------------------------------------------------------------------------
// cache_set_access_cost_model_tb: stimulus and verdict for the cost model
// Runs a short directed sequence through every operation and corner of the
// set, then random phases that rewrite all registers between bursts of
// loads, stores and flush queries over small tag pools. The checker beside
// the block predicts and compares; this module only drives and judges.
// ----------------------------------------------------------------------------
module cache_set_access_cost_model_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// codes the block has no name for: an unused operation and a register
	// index past the last one
	localparam logic [csac_pkg::FUNC_W-1:0]    FUNC_NONE = 2'd3;
	localparam logic [csac_pkg::CFG_IDX_W-1:0] CFG_NONE  = 3'd7;

	localparam int RAND_WORDS = 500;
	localparam int LONG_HOLD  = 300;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [csac_pkg::TAG_W-1:0]      s_tdata   = '0;   // [31:0] tag
	logic [csac_pkg::FUNC_W-1:0]     s_tuser   = '0;   // [1:0] func
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [csac_pkg::CYC_W+1:0]      m_tdata;          // [0] hit, [22:1] cycles,
	                                                   // [23] bad_combination
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [csac_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [csac_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	int pending, errors, n_checked, n_hits, n_bad;
	int n_sent = 0;
	int n_cfg  = 0;

	// sender pacing: words left in the current burst, and whether the
	// current phase runs without gaps
	int unsigned burst_left = 0;
	bit          steady     = 1'b0;
	bit          rand_started = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	cache_set_access_cost_model uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cache_set_access_cost_model_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pending   (pending),
		.errors    (errors),
		.n_checked (n_checked),
		.n_hits    (n_hits),
		.n_bad     (n_bad)
	);

	// Offer one word and hold it until taken. Valid stays high into the
	// next word unless the burst ends with a gap, so a gap can land in
	// either the lookup or the update cycle of the word in flight.
	task automatic send(input logic [csac_pkg::FUNC_W-1:0] f,
		input logic [csac_pkg::TAG_W-1:0] t);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= t;
		do @(posedge clk); while (!s_tready);
		n_sent++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = steady ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// Drop valid and wait until every predicted result has come back. The
	// first edge lets the checker take in the last accepted word.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write one register; call only after settle().
	task automatic set_reg(input logic [csac_pkg::CFG_IDX_W-1:0] idx,
		input logic [csac_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		n_cfg++;
	endtask

	// Receiver: stretches of always-ready, random stalls and a fixed
	// three-of-four pattern; once the random part has begun and the sender
	// is offering, hold off for a long stretch so the result register
	// fills and the input backs up.
	initial begin : result_side
		int unsigned style, span, beat;
		bit          held;
		held = 1'b0;
		beat = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rand_started && !held && s_tvalid) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			style = $urandom_range(0, 3);
			span  = $urandom_range(16, 64);
			repeat (span) begin
				case (style)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 1) == 1);
					default: m_tready <= ((beat % 4) != 3);
				endcase
				beat++;
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [csac_pkg::TAG_W-1:0]      tag_pool [16];
		logic [csac_pkg::FUNC_W-1:0]     f;
		logic [csac_pkg::TAG_W-1:0]      t;
		logic [csac_pkg::CFG_DATA_W-1:0] v;
		int unsigned                     pool_n, phase_len, sel;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, starting from the reset settings: write-allocate,
		// write-back, LRU, eight ways, four words per block at a memory cost of 100.
		send(csac_pkg::FUNC_LOAD,  32'h0000_0000);     // cold miss
		send(csac_pkg::FUNC_LOAD,  32'hFFFF_FFFF);     // cold miss, all tag bits high
		send(csac_pkg::FUNC_STORE, 32'h0000_0000);     // write-back hit marks dirty
		send(csac_pkg::FUNC_STORE, 32'h1234_5678);     // store miss with fill
		send(csac_pkg::FUNC_LOAD,  32'h0000_0000);     // hit, moves to young end
		send(csac_pkg::FUNC_FLUSH, 32'hDEAD_BEEF);     // dirty write-back sum
		send(FUNC_NONE,            32'hA5A5_A5A5);     // unused operation
		// shrink below the fill count: misses now evict and append
		settle();
		set_reg(csac_pkg::CFG_WAYS, 10'd2);
		send(csac_pkg::FUNC_LOAD,  32'h5555_5555);
		send(csac_pkg::FUNC_LOAD,  32'hFFFF_FFFF);     // evicts a dirty block
		// no-write-allocate with write-back rejects a store miss
		settle();
		set_reg(csac_pkg::CFG_ALLOC, 10'd0);
		send(csac_pkg::FUNC_STORE, 32'h0DEA_D000);
		// write-through: store miss goes to memory, store hit costs both
		settle();
		set_reg(csac_pkg::CFG_WB, 10'd0);
		send(csac_pkg::FUNC_STORE, 32'h00BE_EF00);
		send(csac_pkg::FUNC_STORE, 32'hFFFF_FFFF);
		// FIFO order with write-allocate back on
		settle();
		set_reg(csac_pkg::CFG_LRU, 10'd0);
		set_reg(csac_pkg::CFG_ALLOC, 10'd1);
		send(csac_pkg::FUNC_LOAD,  32'h5555_5555);
		send(csac_pkg::FUNC_STORE, 32'h7777_7777);
		// zero way count clamps to one; zero costs; write a dead index
		settle();
		set_reg(csac_pkg::CFG_WAYS,  10'd0);
		set_reg(csac_pkg::CFG_WORDS, 10'd0);
		set_reg(csac_pkg::CFG_MEM,   10'd0);
		set_reg(csac_pkg::CFG_CACHE, 10'd0);
		set_reg(CFG_NONE,            10'h3FF);
		send(csac_pkg::FUNC_LOAD,  32'h0000_0001);
		send(csac_pkg::FUNC_FLUSH, 32'h0000_0000);
		// oversize way count clamps to eight; largest costs; fill all
		// ways dirty and flush
		settle();
		set_reg(csac_pkg::CFG_WAYS,  10'd15);
		set_reg(csac_pkg::CFG_WORDS, 10'd511);
		set_reg(csac_pkg::CFG_MEM,   10'd1023);
		set_reg(csac_pkg::CFG_CACHE, 10'd15);
		set_reg(csac_pkg::CFG_WB,    10'd1);
		set_reg(csac_pkg::CFG_LRU,   10'd1);
		for (int i = 2; i < 10; i++)
			send(csac_pkg::FUNC_STORE, 32'(i));
		send(csac_pkg::FUNC_FLUSH, 32'hFFFF_FFFF);

		// Random phases: new settings, a fresh tag pool sized around the
		// way count so hits, evictions and reorders all happen.
		while (n_sent < 25 + RAND_WORDS) begin
			settle();
			set_reg(csac_pkg::CFG_ALLOC, 10'($urandom_range(0, 1023)));
			set_reg(csac_pkg::CFG_WB,    10'($urandom_range(0, 1023)));
			set_reg(csac_pkg::CFG_LRU,   10'($urandom_range(0, 1023)));
			case ($urandom_range(0, 3))
				0: v = 10'd8;
				1: v = 10'($urandom_range(1, 3));
				2: v = 10'($urandom_range(0, 15));
				default: v = 10'($urandom_range(0, 1023));
			endcase
			set_reg(csac_pkg::CFG_WAYS, v);
			case ($urandom_range(0, 3))
				0: v = 10'd1;
				1: v = 10'($urandom_range(1, 8));
				2: v = $urandom_range(0, 1) ? 10'd256 : 10'd511;
				default: v = 10'($urandom_range(0, 1023));
			endcase
			set_reg(csac_pkg::CFG_WORDS, v);
			case ($urandom_range(0, 3))
				0: v = 10'd1;
				1: v = 10'($urandom_range(1, 200));
				2: v = $urandom_range(0, 1) ? 10'd1000 : 10'd1023;
				default: v = 10'($urandom_range(0, 1023));
			endcase
			set_reg(csac_pkg::CFG_MEM, v);
			set_reg(csac_pkg::CFG_CACHE, $urandom_range(0, 1) ? 10'($urandom_range(1, 15))
				: 10'($urandom_range(0, 1023)));
			rand_started = 1'b1;

			pool_n = $urandom_range(3, 16);
			for (int i = 0; i < 16; i++)
				tag_pool[i] = $urandom();
			steady    = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(30, 70);
			repeat (phase_len) begin
				sel = $urandom_range(0, 99);
				if (sel < 45)
					f = csac_pkg::FUNC_LOAD;
				else if (sel < 87)
					f = csac_pkg::FUNC_STORE;
				else if (sel < 96)
					f = csac_pkg::FUNC_FLUSH;
				else
					f = FUNC_NONE;
				if ($urandom_range(0, 9) == 0)
					t = $urandom();
				else
					t = tag_pool[$urandom_range(0, pool_n - 1)];
				send(f, t);
			end
		end

		settle();
		$display("Covered %0d words over %0d register writes, random settings and tag pools.",
			n_sent, n_cfg);
		$display("Checked %0d results: %0d hits, %0d rejected stores, %0d mismatches.",
			n_checked, n_hits, n_bad, errors);
		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// hard stop well past the slowest correct run
	initial begin : watchdog
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
